[sv/loc_pkg.sv]
`timescale 1ns / 1ps

package loc_pkg;

	localparam int unsigned MUL_W  = 30;
	localparam int unsigned PROD_W = 2 * MUL_W;

	localparam logic [6:0] FULL_TRANSPARENCY = 7'd100;
	localparam logic [7:0] CHANNEL_MAX       = 8'd255;
	localparam logic [9:0] SUM_MAX           = 10'd1023;

	// floor(x / 10000) = (x * REM_RECIP) >> REM_SHIFT, exact for x < 2^21
	localparam logic [MUL_W-1:0] REM_RECIP = MUL_W'(3435974);
	localparam int unsigned      REM_SHIFT = 35;

	// floor(x / 1000000) = (x * COL_RECIP) >> COL_SHIFT, exact for x < 2^29
	localparam logic [MUL_W-1:0] COL_RECIP = MUL_W'(562949954);
	localparam int unsigned      COL_SHIFT = 49;

	// floor(x / 100) = (x * WHT_RECIP) >> WHT_SHIFT, exact for x < 2^15
	localparam logic [MUL_W-1:0] WHT_RECIP = MUL_W'(41944);
	localparam int unsigned      WHT_SHIFT = 22;

	typedef struct packed {
		logic       valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} res_t;

endpackage

[sv/loc_mul.sv]
`timescale 1ns / 1ps

module loc_mul (
	input  logic                       clk,
	input  logic [loc_pkg::MUL_W-1:0]  mul_a,
	input  logic [loc_pkg::MUL_W-1:0]  mul_b,
	output logic [loc_pkg::PROD_W-1:0] prod_q
);
	import loc_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

endmodule

[sv/loc_core.sv]
`timescale 1ns / 1ps

module loc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,
	input  logic [6:0]        alpha_pct,
	input  logic [6:0]        layer_opacity,
	input  logic              layer_included,
	input  logic              last_layer,
	input  logic              res_ready,
	output loc_pkg::res_t     res
);
	import loc_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_MPA   = 13'b0000000000010,
		ST_MPR   = 13'b0000000000100,
		ST_MDROP = 13'b0000000001000,
		ST_MCR   = 13'b0000000010000,
		ST_DR    = 13'b0000000100000,
		ST_MCG   = 13'b0000001000000,
		ST_DG    = 13'b0000010000000,
		ST_MCB   = 13'b0000100000000,
		ST_DB    = 13'b0001000000000,
		ST_FIN   = 13'b0010000000000,
		ST_WHT   = 13'b0100000000000,
		ST_WDN   = 13'b1000000000000
	} state_t;

	state_t            state_q, state_d;
	logic [7:0]        red_q, green_q, blue_q;
	logic [6:0]        alpha_q, opac_q;
	logic              last_q;
	logic [6:0]        rem_q;
	logic [9:0]        sum_red_q, sum_green_q, sum_blue_q;
	logic [20:0]       contrib_q;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_q;
	logic [9:0]        col_q;
	logic [7:0]        drop;
	logic [7:0]        white;
	logic [14:0]       rem_x255;
	logic              accept;

	function automatic logic [9:0] add_sat(input logic [9:0] acc, input logic [9:0] add);
		logic [10:0] s;
		s = {1'b0, acc} + {1'b0, add};
		return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[9:0];
	endfunction

	function automatic logic [7:0] sat_chan(input logic [9:0] s, input logic [7:0] w);
		logic [10:0] t;
		t = {1'b0, s} + {3'b000, w};
		return (t > {3'b000, CHANNEL_MAX}) ? CHANNEL_MAX : t[7:0];
	endfunction

	loc_mul u_mul (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.prod_q (prod_q)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign col_q     = prod_q[COL_SHIFT +: 10];
	assign drop      = prod_q[REM_SHIFT +: 8];
	assign white     = prod_q[WHT_SHIFT +: 8];
	assign rem_x255  = {rem_q, 8'd0} - {8'd0, rem_q};

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (layer_included && (rem_q != '0)) state_d = ST_MPA;
					else if (last_layer)                 state_d = ST_WHT;
				end
			end
			ST_MPA: begin
				mul_a   = MUL_W'(opac_q);
				mul_b   = MUL_W'(alpha_q);
				state_d = ST_MPR;
			end
			ST_MPR: begin
				mul_a   = MUL_W'(prod_q[13:0]);
				mul_b   = MUL_W'(rem_q);
				state_d = ST_MDROP;
			end
			ST_MDROP: begin
				mul_a   = MUL_W'(prod_q[20:0]);
				mul_b   = REM_RECIP;
				state_d = ST_MCR;
			end
			ST_MCR: begin
				mul_a   = MUL_W'(red_q);
				mul_b   = MUL_W'(contrib_q);
				state_d = ST_DR;
			end
			ST_DR: begin
				mul_a   = MUL_W'(prod_q[28:0]);
				mul_b   = COL_RECIP;
				state_d = ST_MCG;
			end
			ST_MCG: begin
				mul_a   = MUL_W'(green_q);
				mul_b   = MUL_W'(contrib_q);
				state_d = ST_DG;
			end
			ST_DG: begin
				mul_a   = MUL_W'(prod_q[28:0]);
				mul_b   = COL_RECIP;
				state_d = ST_MCB;
			end
			ST_MCB: begin
				mul_a   = MUL_W'(blue_q);
				mul_b   = MUL_W'(contrib_q);
				state_d = ST_DB;
			end
			ST_DB: begin
				mul_a   = MUL_W'(prod_q[28:0]);
				mul_b   = COL_RECIP;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = last_q ? ST_WHT : ST_IDLE;
			end
			ST_WHT: begin
				mul_a   = MUL_W'(rem_x255);
				mul_b   = WHT_RECIP;
				state_d = ST_WDN;
			end
			ST_WDN: begin
				mul_a   = MUL_W'(rem_x255);
				mul_b   = WHT_RECIP;
				if (res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res.valid = (state_q == ST_WDN) && res_ready;
		res.red   = sat_chan(sum_red_q, white);
		res.green = sat_chan(sum_green_q, white);
		res.blue  = sat_chan(sum_blue_q, white);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= FULL_TRANSPARENCY;
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_MCR: begin
					rem_q <= (drop >= {1'b0, rem_q}) ? '0 : rem_q - drop[6:0];
				end
				ST_MCG: begin
					sum_red_q <= add_sat(sum_red_q, col_q);
				end
				ST_MCB: begin
					sum_green_q <= add_sat(sum_green_q, col_q);
				end
				ST_FIN: begin
					sum_blue_q <= add_sat(sum_blue_q, col_q);
				end
				ST_WDN: begin
					if (res_ready) begin
						rem_q       <= FULL_TRANSPARENCY;
						sum_red_q   <= '0;
						sum_green_q <= '0;
						sum_blue_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
			alpha_q <= alpha_pct;
			opac_q  <= layer_opacity;
			last_q  <= last_layer;
		end
		if (state_q == ST_MDROP) contrib_q <= prod_q[20:0];
	end

endmodule

[sv/layer_opacity_compositor_unit.sv]
`timescale 1ns / 1ps

// Front-to-back compositor for one output pixel: feed the layer samples of a
// pixel front layer first and mark the last one; a single RGB result comes out
// per pixel, with white filling the transparency left over. All arithmetic runs
// through one shared registered 30x30 multiplier, with the divisions done as
// reciprocal multiplies. An included sample with transparency left occupies the
// block for opacity x alpha, x transparency left, the drop division, and a
// multiply and divide per colour; others do not stall. A sample marked last
// adds the white fill, longer if the previous pixel still waits in the output
// register. The input stalls while a sample is being worked on.
module layer_opacity_compositor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [6:0] alpha_pct,
	input  logic [6:0] layer_opacity,
	input  logic       layer_included,
	input  logic       last_layer,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	import loc_pkg::*;

	res_t res;
	logic res_ready;
	logic out_valid_q;
	logic [7:0] red_q, green_q, blue_q;

	assign res_ready = !out_valid_q || !out_stall;

	loc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (in_valid),
		.req_stall      (in_stall),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.alpha_pct      (alpha_pct),
		.layer_opacity  (layer_opacity),
		.layer_included (layer_included),
		.last_layer     (last_layer),
		.res_ready      (res_ready),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			red_q   <= res.red;
			green_q <= res.green;
			blue_q  <= res.blue;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

endmodule

[sv/loc_chk.sv]
`timescale 1ns / 1ps

module loc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       layer_included,
	input logic       last_layer,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out)
			&& $stable(green_out) && $stable(blue_out))
		else $error("stalled pixel changed or dropped");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_layer |=> in_stall)
		else $error("last layer request did not occupy the block");

	a_skip_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !layer_included && !last_layer |=> !in_stall)
		else $error("excluded layer request stalled the input");

	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("pixel emitted without a finishing step");

endmodule

bind layer_opacity_compositor_unit loc_chk u_loc_chk (.*);
